### hw/rtl/lpni_pkg.sv
// ----------------------------------------------------------------------------
// lpni_pkg
// shared types and constants of the polyline / line nearest intersection unit
// ----------------------------------------------------------------------------
package lpni_pkg;

   localparam int CoordBits = 10;
   localparam int HitBits   = 12;
   localparam int DistBits  = 48;
   localparam int TolBits   = 11;
   localparam int AddrBits  = 5;

   localparam logic [TolBits-1:0]  TolReset = 11'd200;
   localparam logic [HitBits-1:0]  HitSat   = '1;
   localparam logic [DistBits-1:0] DistSat  = '1;

   typedef enum logic [2:0] {
      REG_LINE_A    = 3'd0,
      REG_LINE_B    = 3'd1,
      REG_LINE_C    = 3'd2,
      REG_QUERY_X   = 3'd3,
      REG_QUERY_Y   = 3'd4,
      REG_TOLERANCE = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0]  line_a;
      logic signed [31:0]  line_b;
      logic signed [31:0]  line_c;
      logic signed [31:0]  query_x;
      logic signed [31:0]  query_y;
      logic [TolBits-1:0]  tolerance;
   } cfg_type;

   typedef struct packed {
      logic [CoordBits-1:0] vertex_x;
      logic [CoordBits-1:0] vertex_y;
      logic                 last_vertex;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [HitBits-1:0]   hit_total;
      logic [CoordBits-1:0] nearest_u;
      logic [CoordBits-1:0] nearest_v;
      logic [DistBits-1:0]  nearest_dist_sq;
   } rsp_type;

endpackage

### hw/rtl/line_polyline_nearest_intersection_unit.sv
// ----------------------------------------------------------------------------
// line_polyline_nearest_intersection_unit
// intersects each polyline segment with a configured line and reports the
// hit nearest a query point when the last vertex arrives
// ----------------------------------------------------------------------------
//   channel   direction  handshake          word
//   req       in         req_valid/ready    vertex_x, vertex_y, last_vertex
//   rsp       out        rsp_valid/ready    found, hit_total, nearest_*
//   csr       in         apb psel/penable   line_a..tolerance
//
// first vertex of a polyline: stored as the segment start, with no hit test
// later vertex: the shared 34x34 multiplier forms the line terms; a hit then
// runs the 10-step restoring divider per axis and the distance steps, while
// a parallel or out-of-span segment leaves before the divider
// reset is synchronous; the result word waits in an output register, and a
// new vertex is taken while it waits; only the next last vertex stalls on it
// ----------------------------------------------------------------------------
module line_polyline_nearest_intersection_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lpni_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lpni_pkg::rsp_type         rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [lpni_pkg::AddrBits-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import lpni_pkg::*;

   typedef enum logic [19:0] {
      S_IDLE = 20'h00001, S_M0  = 20'h00002, S_M1  = 20'h00004,
      S_M2   = 20'h00008, S_M3  = 20'h00010, S_M4  = 20'h00020,
      S_NEG  = 20'h00040, S_RNG = 20'h00080, S_PL  = 20'h00100,
      S_PH   = 20'h00200, S_PA  = 20'h00400, S_DIV = 20'h00800,
      S_FIX  = 20'h01000, S_D0  = 20'h02000, S_D1  = 20'h04000,
      S_D2   = 20'h08000, S_D3  = 20'h10000, S_UPD = 20'h20000,
      S_WRAP = 20'h40000, S_EMIT = 20'h80000
   } state_type;

   cfg_type cfg;

   lpni_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   state_type state_ff, state_in;
   logic [CoordBits-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [CoordBits-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic                 last_ff, last_in, have_prev_ff, have_prev_in;
   logic signed [10:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [HitBits-1:0]   hit_ff, hit_in;
   logic [DistBits-1:0]  best_ff, best_in;
   logic [CoordBits-1:0] best_u_ff, best_u_in, best_v_ff, best_v_in;
   logic signed [67:0]   p_ff, p_in;
   logic signed [45:0]   den_ff, den_in, num_ff, num_in;
   logic [55:0]          rem_ff, rem_in, dv_ff, dv_in;
   logic [9:0]           q_ff, q_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic                 axis_ff, axis_in;
   logic [CoordBits-1:0] u_ff, u_in, v_ff, v_in;
   logic [31:0]          au_ff, au_in, av_ff, av_in;
   logic                 sat_ff, sat_in;
   logic [64:0]          s_ff, s_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic signed [33:0] ma, mb;
   logic               mul_en;
   logic signed [10:0] d_sel;
   logic [9:0]         d_abs;
   logic [CoordBits-1:0] x0_sel;
   logic [10:0]        coord;
   logic signed [33:0] du, dv_q;
   logic [33:0]        du_abs, dv_abs;
   logic [DistBits-1:0] seg_dist;
   logic               emit_go;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign d_sel  = axis_ff ? dy_ff : dx_ff;
   assign x0_sel = axis_ff ? prev_y_ff : prev_x_ff;
   always_comb begin
      d_abs = d_sel[10] ? 10'(-d_sel) : d_sel[9:0];
   end

   // shared multiplier operand select
   always_comb begin
      ma = '0;
      mb = '0;
      mul_en = 1'b1;
      case (state_ff)
         S_M0:   begin ma = 34'(cfg.line_a); mb = 34'(dx_ff); end
         S_M1:   begin ma = 34'(cfg.line_b); mb = 34'(dy_ff); end
         S_M2:   begin ma = 34'(cfg.line_a); mb = {24'b0, prev_x_ff}; end
         S_M3:   begin ma = 34'(cfg.line_b); mb = {24'b0, prev_y_ff}; end
         S_PL:   begin ma = {12'b0, num_ff[21:0]}; mb = {24'b0, d_abs}; end
         S_PH:   begin ma = {12'b0, num_ff[43:22]}; mb = {24'b0, d_abs}; end
         S_D1:   begin ma = {2'b0, au_ff}; mb = {2'b0, au_ff}; end
         S_D2:   begin ma = {2'b0, av_ff}; mb = {2'b0, av_ff}; end
         S_WRAP: begin ma = {23'b0, cfg.tolerance}; mb = {23'b0, cfg.tolerance}; end
         default: mul_en = 1'b0;
      endcase
      p_in = mul_en ? ma * mb : p_ff;
   end

   always_comb begin
      if (d_sel[10])
         coord = {1'b0, x0_sel} - {1'b0, q_ff} - {10'b0, (rem_ff != '0)};
      else
         coord = {1'b0, x0_sel} + {1'b0, q_ff};
      du = 34'({8'b0, u_ff, 16'b0}) - 34'(cfg.query_x);
      dv_q = 34'({8'b0, v_ff, 16'b0}) - 34'(cfg.query_y);
      du_abs = du[33] ? 34'(-du) : du;
      dv_abs = dv_q[33] ? 34'(-dv_q) : dv_q;
      seg_dist = (sat_ff || s_ff[64]) ? DistSat : s_ff[63:16];
   end

   always_comb begin
      state_in = state_ff;
      prev_x_in = prev_x_ff; prev_y_in = prev_y_ff;
      cur_x_in = cur_x_ff; cur_y_in = cur_y_ff;
      last_in = last_ff; have_prev_in = have_prev_ff;
      dx_in = dx_ff; dy_in = dy_ff;
      hit_in = hit_ff; best_in = best_ff;
      best_u_in = best_u_ff; best_v_in = best_v_ff;
      den_in = den_ff; num_in = num_ff;
      rem_in = rem_ff; dv_in = dv_ff; q_in = q_ff; cnt_in = cnt_ff;
      axis_in = axis_ff; u_in = u_ff; v_in = v_ff;
      au_in = au_ff; av_in = av_ff; sat_in = sat_ff; s_in = s_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_x_in = req_data.vertex_x;
               cur_y_in = req_data.vertex_y;
               last_in  = req_data.last_vertex;
               dx_in = $signed({1'b0, req_data.vertex_x}) - $signed({1'b0, prev_x_ff});
               dy_in = $signed({1'b0, req_data.vertex_y}) - $signed({1'b0, prev_y_ff});
               state_in = have_prev_ff ? S_M0 : S_WRAP;
            end
         end
         S_M0: state_in = S_M1;
         S_M1: begin
            den_in = p_ff[45:0];
            state_in = S_M2;
         end
         S_M2: begin
            den_in = den_ff + p_ff[45:0];
            state_in = S_M3;
         end
         S_M3: begin
            num_in = -46'(cfg.line_c) - p_ff[45:0];
            state_in = S_M4;
         end
         S_M4: begin
            num_in = num_ff - p_ff[45:0];
            state_in = S_NEG;
         end
         S_NEG: begin
            // parallel or degenerate segment gives no hit
            if (den_ff == '0) begin
               state_in = S_WRAP;
            end else begin
               if (den_ff[45]) begin
                  den_in = -den_ff;
                  num_in = -num_ff;
               end
               state_in = S_RNG;
            end
         end
         S_RNG: begin
            axis_in = 1'b0;
            state_in = (num_ff[45] || num_ff > den_ff) ? S_WRAP : S_PL;
         end
         S_PL: state_in = S_PH;
         S_PH: begin
            rem_in = p_ff[55:0];
            state_in = S_PA;
         end
         S_PA: begin
            rem_in = rem_ff + {p_ff[33:0], 22'b0};
            dv_in  = {1'b0, den_ff, 9'b0};
            q_in   = '0;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_ff >= dv_ff) begin
               rem_in = rem_ff - dv_ff;
               q_in = {q_ff[8:0], 1'b1};
            end else begin
               q_in = {q_ff[8:0], 1'b0};
            end
            dv_in = dv_ff >> 1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd9) state_in = S_FIX;
         end
         S_FIX: begin
            if (!axis_ff) begin
               u_in = coord[9:0];
               axis_in = 1'b1;
               state_in = S_PL;
            end else begin
               v_in = coord[9:0];
               state_in = S_D0;
            end
         end
         S_D0: begin
            au_in = du_abs[31:0];
            av_in = dv_abs[31:0];
            sat_in = (du_abs[33:32] != 2'b0) || (dv_abs[33:32] != 2'b0);
            state_in = S_D1;
         end
         S_D1: state_in = S_D2;
         S_D2: begin
            s_in = {1'b0, p_ff[63:0]};
            state_in = S_D3;
         end
         S_D3: begin
            s_in = s_ff + {1'b0, p_ff[63:0]};
            state_in = S_UPD;
         end
         S_UPD: begin
            if (hit_ff != HitSat) hit_in = hit_ff + 1'b1;
            // strict less-than keeps the earliest of equal hits
            if (hit_ff == '0 || seg_dist < best_ff) begin
               best_in = seg_dist;
               best_u_in = u_ff;
               best_v_in = v_ff;
            end
            state_in = S_WRAP;
         end
         S_WRAP: begin
            prev_x_in = cur_x_ff;
            prev_y_in = cur_y_ff;
            have_prev_in = 1'b1;
            state_in = last_ff ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_in.found = (hit_ff != '0) &&
                              (best_ff < {10'b0, p_ff[21:0], 16'b0});
               rsp_in.hit_total = hit_ff;
               rsp_in.nearest_u = (hit_ff != '0) ? best_u_ff : '0;
               rsp_in.nearest_v = (hit_ff != '0) ? best_v_ff : '0;
               rsp_in.nearest_dist_sq = best_ff;
               prev_x_in = '0;
               prev_y_in = '0;
               have_prev_in = 1'b0;
               hit_in = '0;
               best_in = DistSat;
               best_u_in = '0;
               best_v_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         have_prev_ff <= 1'b0;
         hit_ff <= '0;
         best_ff <= DistSat;
         best_u_ff <= '0;
         best_v_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         axis_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         have_prev_ff <= have_prev_in;
         hit_ff <= hit_in;
         best_ff <= best_in;
         best_u_ff <= best_u_in;
         best_v_ff <= best_v_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         axis_ff <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      last_ff <= last_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      p_ff <= p_in;
      den_ff <= den_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      dv_ff <= dv_in;
      q_ff <= q_in;
      u_ff <= u_in;
      v_ff <= v_in;
      au_ff <= au_in;
      av_ff <= av_in;
      sat_ff <= sat_in;
      s_ff <= s_in;
      rsp_ff <= rsp_in;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (hit_ff == '0) && !have_prev_ff && rsp_valid_ff)
      else $error("polyline state not cleared after result");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff <= 4'd9))
      else $error("divider ran past its steps");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == 4'd9) |=> (state_ff == S_FIX))
      else $error("divider did not hand over to fixup");

endmodule

### hw/rtl/lpni_regs.sv
// ----------------------------------------------------------------------------
// lpni_regs
// apb register file holding the line, query point and tolerance
// ----------------------------------------------------------------------------
module lpni_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [lpni_pkg::AddrBits-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   output lpni_pkg::cfg_type         cfg
);
   import lpni_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[AddrBits-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_LINE_A:    cfg_in.line_a    = pwdata;
            REG_LINE_B:    cfg_in.line_b    = pwdata;
            REG_LINE_C:    cfg_in.line_c    = pwdata;
            REG_QUERY_X:   cfg_in.query_x   = pwdata;
            REG_QUERY_Y:   cfg_in.query_y   = pwdata;
            REG_TOLERANCE: cfg_in.tolerance = pwdata[TolBits-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_LINE_A:    prdata = cfg_ff.line_a;
         REG_LINE_B:    prdata = cfg_ff.line_b;
         REG_LINE_C:    prdata = cfg_ff.line_c;
         REG_QUERY_X:   prdata = cfg_ff.query_x;
         REG_QUERY_Y:   prdata = cfg_ff.query_y;
         REG_TOLERANCE: prdata = {21'b0, cfg_ff.tolerance};
         default:       prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_a    <= '0;
         cfg_ff.line_b    <= '0;
         cfg_ff.line_c    <= '0;
         cfg_ff.query_x   <= '0;
         cfg_ff.query_y   <= '0;
         cfg_ff.tolerance <= TolReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### dv/line_polyline_nearest_intersection_unit_test.sv
// ----------------------------------------------------------------------------
// line_polyline_nearest_intersection_unit_test
// streams polylines into the unit under random stalls, predicts the nearest
// intersection word for every last vertex and compares it field by field
// ----------------------------------------------------------------------------
module line_polyline_nearest_intersection_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lpni_pkg::*;

   localparam longint CycleLimit = 3000000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic psel, penable, pwrite, pready;
   logic [AddrBits-1:0] paddr;
   logic [31:0] pwdata, prdata;

   line_polyline_nearest_intersection_unit dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // predictor state
   longint p_a, p_b, p_c, p_qx, p_qy, p_tol;
   longint pv_x, pv_y, p_hits;
   bit pv_have;
   logic [47:0] p_best;
   logic [9:0] p_bu, p_bv;

   rsp_type expected_words[$];
   int errors = 0;
   longint cycles = 0;
   bit quiet = 0;

   function automatic void clear_track();
      pv_x = 0; pv_y = 0; pv_have = 0; p_hits = 0;
      p_best = '1; p_bu = 0; p_bv = 0;
   endfunction

   function automatic longint axis_hit(longint p0, longint d, longint num, longint den);
      logic [127:0] prod;
      logic [127:0] q, r;
      longint ad;
      ad = d < 0 ? -d : d;
      prod = 128'(num) * 128'(ad);
      q = prod / 128'(den);
      r = prod % 128'(den);
      if (d >= 0) return p0 + longint'(q);
      return p0 - longint'(q) - (r != 0 ? 1 : 0);
   endfunction

   function automatic logic [47:0] sq_distance(longint u, longint v);
      longint du, dv;
      logic [63:0] au, av;
      logic [64:0] s;
      du = u * 65536 - p_qx;
      dv = v * 65536 - p_qy;
      au = du < 0 ? -du : du;
      av = dv < 0 ? -dv : dv;
      if (au > 64'hFFFF_FFFF || av > 64'hFFFF_FFFF) return '1;
      s = 65'(au * au) + 65'(av * av);
      if (s[64]) return '1;
      return s[63:16];
   endfunction

   function automatic void track_vertex(req_type w);
      longint x, y, dx, dy, den, num, u, v;
      logic [47:0] d;
      bit first;
      rsp_type r;
      x = w.vertex_x; y = w.vertex_y;
      if (pv_have) begin
         dx = x - pv_x; dy = y - pv_y;
         den = p_a * dx + p_b * dy;
         if (den != 0) begin
            num = -(p_a * pv_x + p_b * pv_y + p_c);
            if (den < 0) begin
               den = -den; num = -num;
            end
            if (num >= 0 && num <= den) begin
               u = axis_hit(pv_x, dx, num, den);
               v = axis_hit(pv_y, dy, num, den);
               d = sq_distance(u, v);
               first = (p_hits == 0);
               if (p_hits < 4095) p_hits++;
               if (first || d < p_best) begin
                  p_best = d; p_bu = u[9:0]; p_bv = v[9:0];
               end
            end
         end
      end
      pv_x = x; pv_y = y; pv_have = 1;
      if (w.last_vertex) begin
         r.found = (p_hits > 0) && (p_best < (48'(p_tol * p_tol) << 16));
         r.hit_total = p_hits[11:0];
         r.nearest_u = p_hits > 0 ? p_bu : '0;
         r.nearest_v = p_hits > 0 ? p_bv : '0;
         r.nearest_dist_sq = p_best;
         expected_words.push_back(r);
         clear_track();
      end
   endfunction

   // response side: random stall, compare on acceptance
   always @(negedge clock) begin
      if (!reset) rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word %h", rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_words.pop_front();
            if (e.found !== rsp_data.found) begin
               $error("found exp %0d got %0d", e.found, rsp_data.found); errors++;
            end
            if (e.hit_total !== rsp_data.hit_total) begin
               $error("hit_total exp %0d got %0d", e.hit_total, rsp_data.hit_total);
               errors++;
            end
            if (e.nearest_u !== rsp_data.nearest_u) begin
               $error("nearest_u exp %0d got %0d", e.nearest_u, rsp_data.nearest_u);
               errors++;
            end
            if (e.nearest_v !== rsp_data.nearest_v) begin
               $error("nearest_v exp %0d got %0d", e.nearest_v, rsp_data.nearest_v);
               errors++;
            end
            if (e.nearest_dist_sq !== rsp_data.nearest_dist_sq) begin
               $error("nearest_dist_sq exp %h got %h", e.nearest_dist_sq,
                      rsp_data.nearest_dist_sq);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= AddrBits'(4 * int'(idx)); pwdata <= value;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_LINE_A:    p_a = longint'(signed'(value));
         REG_LINE_B:    p_b = longint'(signed'(value));
         REG_LINE_C:    p_c = longint'(signed'(value));
         REG_QUERY_X:   p_qx = longint'(signed'(value));
         REG_QUERY_Y:   p_qy = longint'(signed'(value));
         REG_TOLERANCE: p_tol = value[10:0];
         default: ;
      endcase
   endtask

   // valid is dropped only by an idle gap or by drain, one update per edge
   task automatic send_vertex(logic [9:0] x, logic [9:0] y, bit last);
      req_type w;
      if (!quiet) begin
         while ($urandom_range(99) < 8) begin
            req_valid <= 0;
            @(negedge clock);
         end
      end
      w.vertex_x = x; w.vertex_y = y; w.last_vertex = last;
      req_valid <= 1; req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_vertex(w);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      // a missing trailing segment may still be in flight
      repeat (60) @(posedge clock);
   endtask

   task automatic random_line();
      int mode;
      mode = $urandom_range(9);
      // mostly lines that cross the screen: c = -(a*px + b*py)
      if (mode == 0) begin
         csr_write(REG_LINE_A, $urandom()); csr_write(REG_LINE_B, $urandom());
         csr_write(REG_LINE_C, $urandom());
      end else begin
         int sa, sb, px, py;
         sa = int'($urandom_range(4000)) - 2000;
         sb = int'($urandom_range(4000)) - 2000;
         if (mode == 1) sa = 0;
         if (mode == 2) sb = 0;
         px = $urandom_range(1023); py = $urandom_range(1023);
         csr_write(REG_LINE_A, sa * 16 + $urandom_range(15));
         csr_write(REG_LINE_B, sb * 16 + $urandom_range(15));
         csr_write(REG_LINE_C, -(sa * 16 * px + sb * 16 * py) + int'($urandom_range(200)));
      end
      csr_write(REG_QUERY_X, ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1023) << 16
                | $urandom_range(65535));
      csr_write(REG_QUERY_Y, ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1023) << 16
                | $urandom_range(65535));
      csr_write(REG_TOLERANCE, ($urandom_range(4) == 0) ? $urandom_range(2047)
                : $urandom_range(400));
   endtask

   typedef struct {
      logic [9:0] x, y;
      bit last;
      bit check;
      rsp_type word;
   } vector_row;

   vector_row directed_rows[5] = '{
      // single vertex after reset
      '{10'd5, 10'd5, 1'b1, 1'b1, '{1'b0, 12'd0, 10'd0, 10'd0, 48'hFFFF_FFFF_FFFF}},
      // parallel: zero-length segment with a = b = 0
      '{10'd0, 10'd0, 1'b0, 1'b0, '0},
      '{10'd0, 10'd0, 1'b1, 1'b1, '{1'b0, 12'd0, 10'd0, 10'd0, 48'hFFFF_FFFF_FFFF}},
      '{10'd1023, 10'd1023, 1'b0, 1'b0, '0},
      '{10'd0, 10'd1023, 1'b1, 1'b1, '{1'b0, 12'd0, 10'd0, 10'd0, 48'hFFFF_FFFF_FFFF}}
   };

   vector_row line_rows[8] = '{
      '{10'd0, 10'd0, 1'b0, 1'b0, '0},
      '{10'd1023, 10'd1023, 1'b0, 1'b0, '0},
      '{10'd0, 10'd1023, 1'b0, 1'b0, '0},
      '{10'd1023, 10'd0, 1'b0, 1'b0, '0},
      '{10'd500, 10'd500, 1'b0, 1'b0, '0},
      '{10'd500, 10'd500, 1'b0, 1'b0, '0},
      '{10'd100, 10'd900, 1'b1, 1'b0, '0},
      '{10'd1023, 10'd0, 1'b1, 1'b0, '0}
   };

   initial begin
      int made;
      reset = 1; req_valid = 0; req_data = '0; rsp_ready = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      p_a = 0; p_b = 0; p_c = 0; p_qx = 0; p_qy = 0; p_tol = 200;
      clear_track();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed_rows[i]) begin
         send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last);
         if (directed_rows[i].check && expected_words[$] != directed_rows[i].word) begin
            $error("directed row %0d predicted %h", i, expected_words[$]);
            errors++;
         end
      end
      drain();

      // diagonal x - y = 0, then vertical x = 512 (b = 0), then horizontal (a = 0), then a = b = most negative
      for (int s = 0; s < 4; s++) begin
         case (s)
            0: begin
               csr_write(REG_LINE_A, 32'h0001_0000); csr_write(REG_LINE_B, 32'hFFFF_0000);
               csr_write(REG_LINE_C, 32'h0); csr_write(REG_QUERY_X, 32'h01F4_0000);
               csr_write(REG_QUERY_Y, 32'h01F4_0000); csr_write(REG_TOLERANCE, 32'd2047);
            end
            1: begin
               csr_write(REG_LINE_A, 32'h0001_0000); csr_write(REG_LINE_B, 32'h0);
               csr_write(REG_LINE_C, 32'hFE00_0000); csr_write(REG_TOLERANCE, 32'd0);
            end
            2: begin
               csr_write(REG_LINE_A, 32'h0); csr_write(REG_LINE_B, 32'h7FFF_FFFF);
               csr_write(REG_LINE_C, 32'h8000_0000); csr_write(REG_QUERY_X, 32'h8000_0000);
               csr_write(REG_QUERY_Y, 32'h7FFF_FFFF);
            end
            default: begin
               csr_write(REG_LINE_A, 32'h8000_0000); csr_write(REG_LINE_B, 32'h8000_0000);
               csr_write(REG_LINE_C, 32'h7FFF_FFFF); csr_write(REG_TOLERANCE, 32'd1);
            end
         endcase
         foreach (line_rows[i]) send_vertex(line_rows[i].x, line_rows[i].y, line_rows[i].last);
         drain();
      end

      made = 0;
      while (made < 1450) begin
         int len;
         bit hot;
         drain();
         random_line();
         quiet = (made > 600 && made < 800);
         len = ($urandom_range(19) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
         hot = $urandom_range(3) != 0;
         for (int k = 0; k < len; k++) begin
            logic [9:0] x, y;
            if (hot && $urandom_range(5) == 0) begin
               x = $urandom_range(1) ? 10'd1023 : 10'd0;
               y = $urandom_range(1) ? 10'd1023 : 10'd0;
            end else begin
               x = 10'($urandom()); y = 10'($urandom());
            end
            send_vertex(x, y, k == len - 1);
            made++;
         end
      end
      quiet = 0;
      drain();

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
